[src/mpt_pkg.sv]
package mpt_pkg;

  localparam int MOD_WIDTH = 32;
  localparam int MODULUS_W = 32;
  localparam int BASE_W    = 32;
  localparam int DEPTH_W   = 6;
  localparam int VALUE_W   = 32;

  // Dividend width of the remainder unit: a full product, or the base if wider.
  localparam int PROD_W = 2 * MOD_WIDTH;
  localparam int DIV_W  = (PROD_W > BASE_W) ? PROD_W : BASE_W;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  localparam logic [MODULUS_W-1:0] MODULUS_RESET = MODULUS_W'(1000000);

  typedef struct packed {
    logic accept;
    logic take_base;
    logic init_pow;
    logic end_level;
    logic mul_acc;
    logic mul_sq;
    logic rem_prod;
    logic set_acc;
    logic set_sq;
    logic shift_e;
    logic out_load;
  } mpt_cmd_t;

  typedef struct packed {
    logic depth_zero;
    logic rem_done;
    logic level_done;
    logic e_zero;
    logic e_odd;
    logic e_one;
    logic out_free;
  } mpt_status_t;

endpackage

[src/mpt_if.sv]
interface mpt_in_if;
  logic                          valid;
  logic                          ready;
  logic [mpt_pkg::BASE_W-1:0]    base;
  logic [mpt_pkg::DEPTH_W-1:0]   depth;

  modport source (output valid, output base, output depth, input ready);
  modport sink   (input valid, input base, input depth, output ready);
endinterface

interface mpt_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpt_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mpt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mpt_pkg::MODULUS_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/modular_power_tower.sv]
// Modular power tower: for each item (base, depth) returns one value, the tower
// base^base^...^base of the given depth reduced modulo the modulus register,
// evaluated from the top with every exponent taken as the reduced value of the
// level below. Depth 0 returns 1; depth 1 returns base mod m; a modulus of 0
// acts as 1. One item is worked at a time. All arithmetic runs on one 32x32
// multiplier and one serial remainder unit that retires one dividend bit per
// cycle. An item of depth 0 goes straight to the finishing step. Any other
// item first takes and reduces the base; then for each level above the first
// it raises the base to that level's exponent, with a multiply and a reduction
// for each set exponent bit and a square and a reduction for each exponent
// bit but the last (none for a zero exponent), and then finishes. A finished
// value waits in an output register; the next item is taken as soon as the
// previous value is in that register. Write the modulus only while the block
// is idle.
module modular_power_tower (
  input  logic       clk,
  input  logic       rst,
  mpt_in_if.sink     req,
  mpt_out_if.source  rsp,
  mpt_cfg_if.sink    cfg
);

  mpt_pkg::mpt_cmd_t    cmd;
  mpt_pkg::mpt_status_t st;

  assign cfg.ready = 1'b1;

  mpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mpt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .base      (req.base),
    .depth     (req.depth),
    .cfg_write (cfg.valid),
    .cfg_data  (cfg.data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .value     (rsp.value)
  );

endmodule

[src/mpt_rem.sv]
module mpt_rem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mpt_pkg::DIV_W-1:0]      x,
  input  logic [mpt_pkg::MOD_WIDTH-1:0]  m,
  output logic                           busy,
  output logic                           done,
  output logic [mpt_pkg::MOD_WIDTH-1:0]  rem
);

  logic [mpt_pkg::DIV_W-1:0]     x_sh;
  logic [mpt_pkg::CNT_W-1:0]     cnt;
  logic [mpt_pkg::MOD_WIDTH:0]   trial;
  logic [mpt_pkg::MOD_WIDTH:0]   trial_sub;

  // Restoring remainder: bring in one dividend bit per cycle, msb first.
  assign trial     = {rem, x_sh[mpt_pkg::DIV_W-1]};
  assign trial_sub = trial - {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= mpt_pkg::CNT_W'(mpt_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mpt_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_sh <= x;
      rem  <= '0;
    end else if (busy) begin
      x_sh <= {x_sh[mpt_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, m}) begin
        rem <= trial_sub[mpt_pkg::MOD_WIDTH-1:0];
      end else begin
        rem <= trial[mpt_pkg::MOD_WIDTH-1:0];
      end
    end
  end

endmodule

[src/mpt_dp.sv]
module mpt_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  mpt_pkg::mpt_cmd_t               cmd,
  output mpt_pkg::mpt_status_t            st,
  input  logic [mpt_pkg::BASE_W-1:0]      base,
  input  logic [mpt_pkg::DEPTH_W-1:0]     depth,
  input  logic                            cfg_write,
  input  logic [mpt_pkg::MODULUS_W-1:0]   cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpt_pkg::VALUE_W-1:0]     value
);

  logic [mpt_pkg::MODULUS_W-1:0]   modulus;
  logic [mpt_pkg::MOD_WIDTH-1:0]   m_eff;
  logic [mpt_pkg::MOD_WIDTH-1:0]   one_mod;
  logic [mpt_pkg::DEPTH_W-1:0]     depth_q;
  logic [mpt_pkg::DEPTH_W-1:0]     level;
  logic [mpt_pkg::MOD_WIDTH-1:0]   b;
  logic [mpt_pkg::MOD_WIDTH-1:0]   r;
  logic [mpt_pkg::MOD_WIDTH-1:0]   acc;
  logic [mpt_pkg::MOD_WIDTH-1:0]   sq;
  logic [mpt_pkg::MOD_WIDTH-1:0]   e;
  logic [mpt_pkg::MOD_WIDTH-1:0]   mul_a;
  logic [mpt_pkg::PROD_W-1:0]      mul_p;
  logic [mpt_pkg::PROD_W-1:0]      prod;
  logic                            base_start;
  logic                            rem_start;
  logic [mpt_pkg::DIV_W-1:0]       rem_x;
  logic                            rem_busy;
  logic                            rem_done;
  logic [mpt_pkg::MOD_WIDTH-1:0]   rem_val;
  logic                            out_free;

  // A zero modulus acts as one.
  assign m_eff   = (modulus[mpt_pkg::MOD_WIDTH-1:0] == '0)
                   ? mpt_pkg::MOD_WIDTH'(1) : modulus[mpt_pkg::MOD_WIDTH-1:0];
  assign one_mod = (m_eff == mpt_pkg::MOD_WIDTH'(1))
                   ? '0 : mpt_pkg::MOD_WIDTH'(1);

  assign base_start = cmd.accept && (depth != '0);
  assign rem_start  = base_start || cmd.rem_prod;
  assign rem_x      = base_start ? mpt_pkg::DIV_W'(base) : mpt_pkg::DIV_W'(prod);

  assign mul_a = cmd.mul_sq ? sq : acc;
  assign mul_p = mpt_pkg::PROD_W'(mul_a) * mpt_pkg::PROD_W'(sq);

  assign out_free = !out_valid || out_ready;

  assign st.depth_zero = (depth == '0);
  assign st.rem_done   = rem_done;
  assign st.level_done = (level == depth_q);
  assign st.e_zero     = (e == '0);
  assign st.e_odd      = e[0];
  assign st.e_one      = (e == mpt_pkg::MOD_WIDTH'(1));
  assign st.out_free   = out_free;

  mpt_rem u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (rem_start),
    .x     (rem_x),
    .m     (m_eff),
    .busy  (rem_busy),
    .done  (rem_done),
    .rem   (rem_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= mpt_pkg::MODULUS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        modulus <= cfg_data;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      depth_q <= depth;
      // depth zero gives one, unreduced
      r       <= mpt_pkg::MOD_WIDTH'(1);
    end
    if (cmd.take_base) begin
      b     <= rem_val;
      r     <= rem_val;
      level <= mpt_pkg::DEPTH_W'(1);
    end
    if (cmd.init_pow) begin
      acc <= one_mod;
      sq  <= b;
      e   <= r;
    end
    if (cmd.end_level) begin
      r     <= acc;
      level <= level + 1'b1;
    end
    if (cmd.mul_acc || cmd.mul_sq) begin
      prod <= mul_p;
    end
    if (cmd.set_acc) begin
      acc <= rem_val;
    end
    if (cmd.set_sq) begin
      sq <= rem_val;
    end
    if (cmd.shift_e) begin
      e <= e >> 1;
    end
    if (cmd.out_load) begin
      value <= mpt_pkg::VALUE_W'(r);
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> (rem_val < m_eff))
    else $error("remainder not below modulus");

  a_rem_start_idle: assert property (@(posedge clk) disable iff (rst)
    rem_start |-> !rem_busy)
    else $error("remainder started while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("pending result overwritten");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    cmd.end_level |-> (acc < m_eff))
    else $error("level result not reduced");

endmodule

[src/mpt_ctrl.sv]
module mpt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mpt_pkg::mpt_status_t  st,
  output mpt_pkg::mpt_cmd_t     cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_RED_BASE = 10'b0000000010,
    S_LEVEL    = 10'b0000000100,
    S_EXP      = 10'b0000001000,
    S_MUL_A    = 10'b0000010000,
    S_REM_A    = 10'b0000100000,
    S_SQ       = 10'b0001000000,
    S_MUL_S    = 10'b0010000000,
    S_REM_S    = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = st.depth_zero ? S_FIN : S_RED_BASE;
        end
      end
      S_RED_BASE: begin
        if (st.rem_done) begin
          cmd.take_base = 1'b1;
          state_next    = S_LEVEL;
        end
      end
      S_LEVEL: begin
        if (st.level_done) begin
          state_next = S_FIN;
        end else begin
          cmd.init_pow = 1'b1;
          state_next   = S_EXP;
        end
      end
      S_EXP: begin
        if (st.e_zero) begin
          cmd.end_level = 1'b1;
          state_next    = S_LEVEL;
        end else if (st.e_odd) begin
          cmd.mul_acc = 1'b1;
          state_next  = S_MUL_A;
        end else begin
          state_next = S_SQ;
        end
      end
      S_MUL_A: begin
        cmd.rem_prod = 1'b1;
        state_next   = S_REM_A;
      end
      S_REM_A: begin
        if (st.rem_done) begin
          cmd.set_acc = 1'b1;
          // last exponent bit: the square is never used
          if (st.e_one) begin
            cmd.shift_e = 1'b1;
            state_next  = S_EXP;
          end else begin
            state_next = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = S_MUL_S;
      end
      S_MUL_S: begin
        cmd.rem_prod = 1'b1;
        state_next   = S_REM_S;
      end
      S_REM_S: begin
        if (st.rem_done) begin
          cmd.set_sq  = 1'b1;
          cmd.shift_e = 1'b1;
          state_next  = S_EXP;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
